FILE: rtl/dsumr_pkg.sv
// shared constants, types and address helper for the disjoint-set union block
package dsumr_pkg;

  localparam int NODE_COUNT   = 65536;
  localparam int FOREST_COUNT = 3;

  localparam int NODE_W    = $clog2(NODE_COUNT);
  localparam int FOREST_W  = (FOREST_COUNT > 1) ? $clog2(FOREST_COUNT) : 1;
  localparam int MEM_DEPTH = FOREST_COUNT * NODE_COUNT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic REQ_MERGE = 1'b0;
  localparam logic REQ_FIND  = 1'b1;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [FOREST_W-1:0] forest_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_START_B,
    ST_LINK,
    ST_DONE
  } state_t;

  function automatic addr_t mem_addr(input forest_t f, input node_t n);
    return ADDR_W'(f) * ADDR_W'(NODE_COUNT) + ADDR_W'(n);
  endfunction

endpackage

FILE: rtl/disjoint_set_union_min_root_top.sv
// disjoint-set union with path compression and minimum-index roots
//
// input channel s_*: one request word per handshake; s_tuser carries the
// request kind and forest, s_tdata the two node indices. output channel m_*:
// one root word per request, in request order.
// the parent links of all forests sit in one synchronous memory with one
// write and one read port. a walk reads one link per cycle up to the root,
// then rewrites every link on the path to the root, again one per cycle.
// a find whose node sits d links below its root makes d + 1 reads and d
// rewrites, then loads the output register and raises m_tvalid. a merge with
// paths of d_a and d_b links runs two walks, a restart, a link write and the
// output load. a request with an out of range forest or node answers 0 and
// changes nothing.
// only one request is in flight; the next is accepted in the cycle after its
// result has moved into the output register, which holds while m_tready is
// low, so a stalled receiver holds back at most one further request.
// after rst the memory is cleared to identity links by a pass that writes all
// FOREST_COUNT * NODE_COUNT links (196608 at the default size); no request
// is accepted during that pass.
module disjoint_set_union_min_root_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // node_a[15:0], node_b[31:16]
  input  logic [2:0]  s_tuser,   // req_type[0], forest_sel[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // root_index[15:0]
);

  dsumr_pkg::state_t  state, state_next;
  dsumr_pkg::node_t   cur, cur_next;
  dsumr_pkg::node_t   root, root_next;
  dsumr_pkg::node_t   root_a, root_a_next;
  dsumr_pkg::node_t   start, start_next;
  dsumr_pkg::node_t   result, result_next;
  dsumr_pkg::node_t   node_b;
  dsumr_pkg::forest_t forest;
  logic               req_type;
  logic               phase_b, phase_b_next;
  dsumr_pkg::forest_t clr_forest;
  dsumr_pkg::node_t   clr_node;
  logic               load_out;

  logic               mem_we;
  dsumr_pkg::addr_t   mem_waddr;
  dsumr_pkg::node_t   mem_wdata;
  dsumr_pkg::addr_t   mem_raddr;
  dsumr_pkg::node_t   mem_rdata;
  dsumr_pkg::node_t   mem [dsumr_pkg::MEM_DEPTH];

  logic               in_req;
  logic [1:0]         in_fsel;
  logic [15:0]        in_a;
  logic [15:0]        in_b;
  logic               in_ok;
  dsumr_pkg::forest_t in_forest;
  dsumr_pkg::node_t   in_node_a;
  dsumr_pkg::node_t   in_node_b;
  logic               clr_node_last;
  logic               clr_forest_last;

  assign in_req    = s_tuser[0];
  assign in_fsel   = s_tuser[2:1];
  assign in_a      = s_tdata[15:0];
  assign in_b      = s_tdata[31:16];
  assign in_forest = dsumr_pkg::FOREST_W'(in_fsel);
  assign in_node_a = dsumr_pkg::NODE_W'(in_a);
  assign in_node_b = dsumr_pkg::NODE_W'(in_b);
  assign in_ok     = ({30'd0, in_fsel} < dsumr_pkg::FOREST_COUNT) &&
                     ({16'd0, in_a} < dsumr_pkg::NODE_COUNT) &&
                     ((in_req == dsumr_pkg::REQ_FIND) ||
                      ({16'd0, in_b} < dsumr_pkg::NODE_COUNT));

  assign clr_node_last   = (clr_node == dsumr_pkg::NODE_W'(dsumr_pkg::NODE_COUNT - 1));
  assign clr_forest_last = (clr_forest == dsumr_pkg::FOREST_W'(dsumr_pkg::FOREST_COUNT - 1));

  // parent link memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dsumr_pkg::ST_CLEAR;
      clr_forest <= '0;
      clr_node   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dsumr_pkg::ST_CLEAR) begin
        if (clr_node_last) begin
          clr_node   <= '0;
          clr_forest <= clr_forest + dsumr_pkg::FOREST_W'(1);
        end else begin
          clr_node <= clr_node + dsumr_pkg::NODE_W'(1);
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    root    <= root_next;
    root_a  <= root_a_next;
    start   <= start_next;
    result  <= result_next;
    phase_b <= phase_b_next;
    if (s_tvalid && s_tready) begin
      req_type <= in_req;
      forest   <= in_forest;
      node_b   <= in_node_b;
    end
    if (load_out) begin
      m_tdata <= 16'(result);
    end
  end

  always_comb begin
    logic             walk_done;
    dsumr_pkg::node_t walk_root;
    dsumr_pkg::node_t lo;
    dsumr_pkg::node_t hi;

    walk_done    = 1'b0;
    walk_root    = root;
    lo           = (root_a < root) ? root_a : root;
    hi           = (root_a < root) ? root : root_a;
    state_next   = state;
    cur_next     = cur;
    root_next    = root;
    root_a_next  = root_a;
    start_next   = start;
    result_next  = result;
    phase_b_next = phase_b;
    s_tready     = 1'b0;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = dsumr_pkg::mem_addr(forest, cur);
    mem_wdata    = root;
    mem_raddr    = dsumr_pkg::mem_addr(forest, cur);

    unique case (state)
      dsumr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = dsumr_pkg::mem_addr(clr_forest, clr_node);
        mem_wdata = clr_node;
        if (clr_node_last && clr_forest_last) begin
          state_next = dsumr_pkg::ST_IDLE;
        end
      end
      dsumr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_ok) begin
            cur_next     = in_node_a;
            start_next   = in_node_a;
            phase_b_next = 1'b0;
            mem_raddr    = dsumr_pkg::mem_addr(in_forest, in_node_a);
            state_next   = dsumr_pkg::ST_FIND;
          end else begin
            result_next = '0;
            state_next  = dsumr_pkg::ST_DONE;
          end
        end
      end
      dsumr_pkg::ST_FIND: begin
        if (mem_rdata == cur) begin
          root_next = cur;
          if (start == cur) begin
            walk_done = 1'b1;
            walk_root = cur;
          end else begin
            cur_next   = start;
            mem_raddr  = dsumr_pkg::mem_addr(forest, start);
            state_next = dsumr_pkg::ST_COMP;
          end
        end else begin
          cur_next  = mem_rdata;
          mem_raddr = dsumr_pkg::mem_addr(forest, mem_rdata);
        end
      end
      dsumr_pkg::ST_COMP: begin
        // point this link at the root, follow the old link
        mem_we    = 1'b1;
        mem_waddr = dsumr_pkg::mem_addr(forest, cur);
        mem_wdata = root;
        if (mem_rdata == root) begin
          walk_done = 1'b1;
          walk_root = root;
        end else begin
          cur_next  = mem_rdata;
          mem_raddr = dsumr_pkg::mem_addr(forest, mem_rdata);
        end
      end
      dsumr_pkg::ST_START_B: begin
        cur_next     = node_b;
        start_next   = node_b;
        phase_b_next = 1'b1;
        mem_raddr    = dsumr_pkg::mem_addr(forest, node_b);
        state_next   = dsumr_pkg::ST_FIND;
      end
      dsumr_pkg::ST_LINK: begin
        mem_we      = 1'b1;
        mem_waddr   = dsumr_pkg::mem_addr(forest, hi);
        mem_wdata   = lo;
        result_next = lo;
        state_next  = dsumr_pkg::ST_DONE;
      end
      dsumr_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = dsumr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dsumr_pkg::ST_IDLE;
      end
    endcase

    if (walk_done) begin
      priority if (req_type == dsumr_pkg::REQ_FIND) begin
        result_next = walk_root;
        state_next  = dsumr_pkg::ST_DONE;
      end else if (!phase_b) begin
        root_a_next = walk_root;
        state_next  = dsumr_pkg::ST_START_B;
      end else begin
        root_next  = walk_root;
        state_next = dsumr_pkg::ST_LINK;
      end
    end
  end

endmodule
